/* sv/wed_pkg.sv */
package wed_pkg;

  localparam int COST_W   = 14;
  localparam int SYM_W    = 8;
  localparam int WEIGHT_W = 8;
  localparam int ACT_W    = 2;
  localparam int MAX_LEN_DEF = 32;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // Input action codes
  localparam logic [ACT_W-1:0] ACT_FIRST   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SECOND  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_INSERT  = 2'd0;
  localparam logic [1:0] REG_DELETE  = 2'd1;
  localparam logic [1:0] REG_REPLACE = 2'd2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd1;

  typedef logic [COST_W-1:0]   cost_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

  // Add a weight to a cost and clamp at the top of the cost range
  function automatic cost_t sat_add(input cost_t a, input weight_t b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {{(COST_W + 1 - WEIGHT_W){1'b0}}, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

endpackage

/* sv/wed_ram.sv */
module wed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/wed_cell.sv */
module wed_cell (
  input  wed_pkg::cost_t   left,
  input  wed_pkg::cost_t   up,
  input  wed_pkg::cost_t   diag,
  input  logic [7:0]       sym_a,
  input  logic [7:0]       sym_b,
  input  wed_pkg::weight_t insert_cost,
  input  wed_pkg::weight_t delete_cost,
  input  wed_pkg::weight_t replace_cost,
  output wed_pkg::cost_t   best
);

  import wed_pkg::*;

  cost_t ins_c;
  cost_t del_c;
  cost_t rep_c;
  cost_t min_id;

  always_comb begin
    ins_c  = sat_add(left, insert_cost);
    del_c  = sat_add(up, delete_cost);
    rep_c  = (sym_a == sym_b) ? diag : sat_add(diag, replace_cost);
    min_id = (del_c < ins_c) ? del_c : ins_c;
    best   = (rep_c < min_id) ? rep_c : min_id;
  end

endmodule

/* sv/weighted_edit_distance_core.sv */
// Weighted edit distance engine. Each input transaction either appends a byte
// to the first or second word (s_tready stays high), asks for the result, or,
// with the unused action code, is ignored. A compute request runs the
// dynamic-programming table one cell per cycle through a single saturating
// add/min cell unit, keeping the working row in a RAM: it seeds row zero from
// the second word, then walks each byte of the first word (a column-zero step,
// then one cell per byte of the second word), then hands the result to the
// output register; s_tready is low meanwhile. The single cost row RAM port
// pair gives one read and one write per cycle. Loads are taken while a
// finished result still waits in the output register. After a compute both
// words and the overflow flag are cleared. Bytes appended to a full word are
// dropped and reported by the overflow bit of the next result. Cost registers
// are to be written through the cfg port only while the engine is idle; the
// block itself does not enforce this.
module weighted_edit_distance_core #(
  parameter int MAX_LEN = wed_pkg::MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream: s_tuser [1:0] action; s_tdata [7:0] symbol
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,
  input  logic [7:0]  s_tdata,
  // Output stream: [13:0] distance, [14] overflow, [15] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  import wed_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);                 // lengths and indexes
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1; // word RAM address
  localparam int CW = $clog2(MAX_LEN + 1);                 // cost row address
  localparam logic [LW-1:0] LEN_FULL = LW'(MAX_LEN);

  typedef enum logic [2:0] {
    IDLE,
    FILL,
    ROW_START,
    CELL,
    DONE
  } state_t;

  state_t state;

  weight_t insert_cost;
  weight_t delete_cost;
  weight_t replace_cost;

  logic [LW-1:0] first_length;
  logic [LW-1:0] second_length;
  logic          dropped_flag;

  logic [LW-1:0] row;   // current row of the first word, 0-based
  logic [LW-1:0] col;   // current cell of the second word
  cost_t         last;  // left neighbor / running result
  cost_t         diag;
  cost_t         col0;  // column-zero cell of the current row

  logic [ACT_W-1:0] action;
  logic [SYM_W-1:0] symbol;
  logic             s_fire;

  // Word and cost-row RAM ports
  logic             fw_we;
  logic             sw_we;
  logic [SYM_W-1:0] fw_rdata;
  logic [SYM_W-1:0] sw_rdata;
  logic             cr_we;
  logic [CW-1:0]    cr_waddr;
  cost_t            cr_wdata;
  cost_t            cr_rdata;
  logic [LW-1:0]    col_plus1;

  cost_t best;
  cost_t fill_val;
  cost_t col0_next;
  logic  out_free;

  assign action   = s_tuser;
  assign symbol   = s_tdata;
  assign s_tready = (state == IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign fw_we = s_fire && (action == ACT_FIRST) && (first_length < LEN_FULL);
  assign sw_we = s_fire && (action == ACT_SECOND) && (second_length < LEN_FULL);

  assign col_plus1 = col + 1'b1;
  assign fill_val  = sat_add(last, insert_cost);
  assign col0_next = sat_add(col0, delete_cost);

  // Write the seeded row-zero value while filling, the new cell while walking
  always_comb begin
    cr_we    = 1'b0;
    cr_waddr = col[CW-1:0];
    cr_wdata = best;
    case (state)
      FILL: begin
        cr_we    = 1'b1;
        cr_wdata = fill_val;
      end
      CELL: begin
        cr_we = 1'b1;
      end
      default: begin
        cr_we = 1'b0;
      end
    endcase
  end

  wed_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_first_word (
    .clk   (clk),
    .we    (fw_we),
    .waddr (first_length[AW-1:0]),
    .wdata (symbol),
    .raddr (row[AW-1:0]),
    .rdata (fw_rdata)
  );

  // Read one cell ahead: second_word[col] and cost_row[col + 1]
  wed_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_second_word (
    .clk   (clk),
    .we    (sw_we),
    .waddr (second_length[AW-1:0]),
    .wdata (symbol),
    .raddr (col[AW-1:0]),
    .rdata (sw_rdata)
  );

  wed_ram #(.WIDTH(COST_W), .DEPTH(MAX_LEN + 1)) u_cost_row (
    .clk   (clk),
    .we    (cr_we),
    .waddr (cr_waddr),
    .wdata (cr_wdata),
    .raddr (col_plus1[CW-1:0]),
    .rdata (cr_rdata)
  );

  wed_cell u_cell (
    .left         (last),
    .up           (cr_rdata),
    .diag         (diag),
    .sym_a        (fw_rdata),
    .sym_b        (sw_rdata),
    .insert_cost  (insert_cost),
    .delete_cost  (delete_cost),
    .replace_cost (replace_cost),
    .best         (best)
  );

  // Cost registers
  always_ff @(posedge clk) begin
    if (rst) begin
      insert_cost  <= WEIGHT_RESET;
      delete_cost  <= WEIGHT_RESET;
      replace_cost <= WEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INSERT:  insert_cost  <= cfg_data;
        REG_DELETE:  delete_cost  <= cfg_data;
        REG_REPLACE: replace_cost <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer, word lengths and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      first_length  <= '0;
      second_length <= '0;
      dropped_flag  <= 1'b0;
      m_tvalid      <= 1'b0;
      row           <= '0;
      col           <= '0;
    end else begin
      // Drop the result once the consumer takes it; DONE reloads the
      // register on its own
      if (m_tvalid && m_tready && (state != DONE)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (s_fire) begin
            case (action)
              ACT_FIRST: begin
                if (first_length < LEN_FULL) begin
                  first_length <= first_length + 1'b1;
                end else begin
                  dropped_flag <= 1'b1;
                end
              end
              ACT_SECOND: begin
                if (second_length < LEN_FULL) begin
                  second_length <= second_length + 1'b1;
                end else begin
                  dropped_flag <= 1'b1;
                end
              end
              ACT_COMPUTE: begin
                last <= '0;
                col0 <= '0;
                row  <= '0;
                if (second_length != '0) begin
                  col   <= LW'(1);
                  state <= FILL;
                end else if (first_length != '0) begin
                  col   <= '0;
                  state <= ROW_START;
                end else begin
                  state <= DONE;
                end
              end
              default: begin
              end
            endcase
          end
        end

        // Seed row zero with multiples of the insert cost
        FILL: begin
          last <= fill_val;
          if (col == second_length) begin
            col   <= '0;
            state <= (first_length != '0) ? ROW_START : DONE;
          end else begin
            col <= col_plus1;
          end
        end

        // Advance column zero; reads for the first cell are in flight
        ROW_START: begin
          diag <= col0;
          col0 <= col0_next;
          last <= col0_next;
          if (second_length != '0) begin
            col   <= LW'(1);
            state <= CELL;
          end else if (row + 1'b1 == first_length) begin
            state <= DONE;
          end else begin
            row <= row + 1'b1;
          end
        end

        CELL: begin
          last <= best;
          diag <= cr_rdata;
          if (col == second_length) begin
            col <= '0;
            if (row + 1'b1 == first_length) begin
              state <= DONE;
            end else begin
              row   <= row + 1'b1;
              state <= ROW_START;
            end
          end else begin
            col <= col_plus1;
          end
        end

        // Hold until the output register is free, then load the result and clear the words and the flag
        DONE: begin
          if (out_free) begin
            m_tvalid      <= 1'b1;
            m_tdata       <= {1'b0, dropped_flag, last};
            first_length  <= '0;
            second_length <= '0;
            dropped_flag  <= 1'b0;
            state         <= IDLE;
          end
        end

        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* test/weighted_edit_distance_core_tb.sv */
module weighted_edit_distance_core_tb;
  import wed_pkg::*;

  localparam int WORD_CAP = MAX_LEN_DEF;
  // The block does nothing with this action and sends no result
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 500;
  localparam int PHASE_COUNT = 7;
  localparam int MAX_GAP = 13;
  // The receiver holds off this long once, so that the output register
  // fills up and the next compute request stalls the input.
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT_RESULT = 8;
  // Let loads and ignored items settle before a cost register changes.
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES = 1200;

  typedef struct packed {
    logic  overflow;
    cost_t distance;
  } edit_result_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [SYM_W-1:0] symbol;
    logic             typed;
    edit_result_t     result;
  } stim_row_t;

  // Directed rows run at the reset costs (all 1). Rows with typed set carry
  // their expected result; the rest are checked against the predictor.
  localparam int DIRECTED_ROWS = 21;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // both words empty right after reset
    '{ACT_COMPUTE, 8'h00, 1'b1, '{1'b0, 14'd0}},
    // unused action, all bits set
    '{ACT_UNUSED,  8'hFF, 1'b0, '{1'b0, 14'd0}},
    // empty second word: one delete
    '{ACT_FIRST,   8'h41, 1'b0, '{1'b0, 14'd0}},
    '{ACT_COMPUTE, 8'h00, 1'b1, '{1'b0, 14'd1}},
    // empty first word: two inserts, symbol extremes
    '{ACT_SECOND,  8'h00, 1'b0, '{1'b0, 14'd0}},
    '{ACT_SECOND,  8'hFF, 1'b0, '{1'b0, 14'd0}},
    '{ACT_COMPUTE, 8'hFF, 1'b1, '{1'b0, 14'd2}},
    // equal bytes cost nothing
    '{ACT_FIRST,   8'hAA, 1'b0, '{1'b0, 14'd0}},
    '{ACT_SECOND,  8'hAA, 1'b0, '{1'b0, 14'd0}},
    '{ACT_COMPUTE, 8'h00, 1'b1, '{1'b0, 14'd0}},
    // differing bytes: one replace
    '{ACT_FIRST,   8'h55, 1'b0, '{1'b0, 14'd0}},
    '{ACT_SECOND,  8'hAA, 1'b0, '{1'b0, 14'd0}},
    '{ACT_COMPUTE, 8'h00, 1'b1, '{1'b0, 14'd1}},
    // mixed edits
    '{ACT_FIRST,   8'h61, 1'b0, '{1'b0, 14'd0}},
    '{ACT_SECOND,  8'h61, 1'b0, '{1'b0, 14'd0}},
    '{ACT_FIRST,   8'h62, 1'b0, '{1'b0, 14'd0}},
    '{ACT_SECOND,  8'h78, 1'b0, '{1'b0, 14'd0}},
    '{ACT_FIRST,   8'h63, 1'b0, '{1'b0, 14'd0}},
    '{ACT_SECOND,  8'h63, 1'b0, '{1'b0, 14'd0}},
    '{ACT_SECOND,  8'h64, 1'b0, '{1'b0, 14'd0}},
    '{ACT_COMPUTE, 8'h00, 1'b0, '{1'b0, 14'd0}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [1:0] action
  logic [1:0]  s_tuser = '0;
  // [7:0] symbol
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [13:0] distance, [14] overflow, [15] zero
  logic [15:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_INSERT;
  logic [7:0]  cfg_data = '0;

  int cycle_count = 0;
  int mismatch_count = 0;
  bit send_quiet = 1'b0;

  // Predictor state: the costs and the two words as the block should hold them
  weight_t          ins_weight, del_weight, rep_weight;
  logic [SYM_W-1:0] first_syms [WORD_CAP];
  logic [SYM_W-1:0] second_syms [WORD_CAP];
  int               first_len, second_len;
  logic             lost_symbol;

  edit_result_t pending_results [$];

  weighted_edit_distance_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("weighted_edit_distance_core regression: fail");
      $finish;
    end
  end

  // Add a weight and clamp at the top of the 14-bit cost range
  function automatic cost_t clamp_add(cost_t base, weight_t w);
    int unsigned total;
    total = int'(base) + int'(w);
    return (total > int'(COST_MAX)) ? COST_MAX : cost_t'(total);
  endfunction

  // Walk the cost table one row at a time, first word down, second across
  function automatic cost_t align_cost();
    cost_t row [WORD_CAP + 1];
    cost_t diag, upper, best, via_del, via_rep;
    row[0] = '0;
    for (int j = 1; j <= second_len; j++) row[j] = clamp_add(row[j - 1], ins_weight);
    for (int i = 1; i <= first_len; i++) begin
      diag = row[0];
      row[0] = clamp_add(row[0], del_weight);
      for (int j = 1; j <= second_len; j++) begin
        upper = row[j];
        best = clamp_add(row[j - 1], ins_weight);
        via_del = clamp_add(upper, del_weight);
        via_rep = (first_syms[i - 1] == second_syms[j - 1]) ? diag
                                                           : clamp_add(diag, rep_weight);
        if (via_del < best) best = via_del;
        if (via_rep < best) best = via_rep;
        diag = upper;
        row[j] = best;
      end
    end
    return row[second_len];
  endfunction

  // Advance the predicted state by one accepted item; return 1 with the
  // expected result when the item is a compute request.
  function automatic bit predict_edit(logic [ACT_W-1:0] act, logic [SYM_W-1:0] sym,
                                      output edit_result_t res);
    res = '0;
    case (act)
      ACT_FIRST: begin
        if (first_len < WORD_CAP) begin
          first_syms[first_len] = sym;
          first_len++;
        end else begin
          lost_symbol = 1'b1;
        end
      end
      ACT_SECOND: begin
        if (second_len < WORD_CAP) begin
          second_syms[second_len] = sym;
          second_len++;
        end else begin
          lost_symbol = 1'b1;
        end
      end
      ACT_COMPUTE: begin
        res.distance = align_cost();
        res.overflow = lost_symbol;
        first_len = 0;
        second_len = 0;
        lost_symbol = 1'b0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Draw a random wait; now and then switch into or out of a stretch with no
  // waits at all.
  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 15) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Word lengths: mostly short, some medium, a few around the capacity so
  // that full words and dropped bytes show up.
  function automatic int draw_len();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return $urandom_range(WORD_CAP - 2, WORD_CAP + 6);
    if (pick < 4) return $urandom_range(9, 20);
    return $urandom_range(0, 8);
  endfunction

  // Offer one item after a random gap and hold it until the transaction
  // completes; then record what the block should answer.
  task automatic feed_item(logic [ACT_W-1:0] act, logic [SYM_W-1:0] sym,
                           bit typed, edit_result_t typed_res);
    int gap;
    edit_result_t res;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= sym;
    do @(posedge clk); while (!s_tready);
    if (predict_edit(act, sym, res)) pending_results.push_back(typed ? typed_res : res);
  endtask

  // Drain the block, then load all three costs while it is idle
  task automatic load_costs(weight_t ins, weight_t del, weight_t rep);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_INSERT;
    cfg_data  <= ins;
    @(posedge clk);
    cfg_index <= REG_DELETE;
    cfg_data  <= del;
    @(posedge clk);
    cfg_index <= REG_REPLACE;
    cfg_data  <= rep;
    @(posedge clk);
    cfg_we <= 1'b0;
    ins_weight = ins;
    del_weight = del;
    rep_weight = rep;
  endtask

  // One pair of words with interleaved appends, then a compute request.
  // Sprinkle ignored items in; now and then leave the compute out so that
  // the words run on into the next pair.
  task automatic run_pair(inout int counted);
    int left_a, left_b;
    bit narrow;
    logic [SYM_W-1:0] base;
    logic [ACT_W-1:0] act;
    left_a = draw_len();
    left_b = draw_len();
    // A narrow alphabet makes matches common
    narrow = $urandom_range(0, 1);
    base = SYM_W'($urandom);
    while (left_a + left_b > 0) begin
      if ($urandom_range(0, 19) == 0) feed_item(ACT_UNUSED, SYM_W'($urandom), 1'b0, '0);
      if (left_b == 0 || (left_a > 0 && $urandom_range(0, 1) == 1)) begin
        act = ACT_FIRST;
        left_a--;
      end else begin
        act = ACT_SECOND;
        left_b--;
      end
      feed_item(act, narrow ? SYM_W'(base + $urandom_range(0, 3)) : SYM_W'($urandom),
                1'b0, '0);
      counted++;
    end
    if ($urandom_range(0, 9) != 0) begin
      feed_item(ACT_COMPUTE, SYM_W'($urandom), 1'b0, '0);
      counted++;
    end
  endtask

  // Stimulus
  initial begin
    int counted;
    weight_t ins, del, rep;
    ins_weight = WEIGHT_RESET;
    del_weight = WEIGHT_RESET;
    rep_weight = WEIGHT_RESET;
    first_len = 0;
    second_len = 0;
    lost_symbol = 1'b0;
    counted = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      feed_item(DIRECTED[k].action, DIRECTED[k].symbol, DIRECTED[k].typed,
                DIRECTED[k].result);
    end

    // Random phases, each under its own cost setting, extremes first
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          ins = 8'd0;
          del = 8'd0;
          rep = 8'd0;
        end
        1: begin
          ins = 8'd255;
          del = 8'd255;
          rep = 8'd255;
        end
        2: begin
          ins = 8'd255;
          del = 8'd0;
          rep = 8'd128;
        end
        3: begin
          ins = 8'd0;
          del = 8'd255;
          rep = 8'd255;
        end
        default: begin
          ins = weight_t'($urandom);
          del = weight_t'($urandom);
          rep = weight_t'($urandom);
        end
      endcase
      load_costs(ins, del, rep);
      while (counted < ITEM_TARGET * (phase + 1) / PHASE_COUNT) run_pair(counted);
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Give a stray result time to show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("weighted_edit_distance_core regression: pass");
    end else begin
      $display("weighted_edit_distance_core regression: fail");
    end
    $finish;
  end

  // Receiver: stall at random, hold off once for a long stretch, and check
  // every result transaction against the oldest expectation.
  initial begin
    int wait_cycles;
    int results_seen;
    bit recv_quiet;
    edit_result_t want;
    results_seen = 0;
    recv_quiet = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      wait_cycles = (results_seen == HOLD_AT_RESULT) ? HOLD_CYCLES : draw_wait(recv_quiet);
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: distance %0d overflow %0d",
               m_tdata[COST_W-1:0], m_tdata[COST_W]);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[COST_W-1:0] !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, m_tdata[COST_W-1:0]);
          mismatch_count++;
        end
        if (m_tdata[COST_W] !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, m_tdata[COST_W]);
          mismatch_count++;
        end
      end
    end
  end

endmodule

/* files.f */
sv/wed_pkg.sv
sv/wed_ram.sv
sv/wed_cell.sv
sv/weighted_edit_distance_core.sv
test/weighted_edit_distance_core_tb.sv
